// ===== sv/c8_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package c8_pkg;

	localparam int MEM_BYTES     = 4096;
	localparam int MEM_AW        = $clog2(MEM_BYTES);
	localparam int STACK_DEPTH   = 16;
	localparam int SP_W          = $clog2(STACK_DEPTH);
	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;
	localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
	localparam int COL_W         = $clog2(SCREEN_WIDTH);
	localparam int PROGRAM_BASE  = 512;
	localparam int FONT_BASE     = 80;
	localparam int GLYPH_BYTES   = 80;

	localparam logic [7:0] GLYPHS [GLYPH_BYTES] = '{
		8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
		8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
		8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
		8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
		8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
	};

	// item modes
	localparam logic [1:0] MODE_PROG = 2'd0;
	localparam logic [1:0] MODE_EXEC = 2'd1;
	localparam logic [1:0] MODE_ROW  = 2'd2;

	// opcode groups (top nibble)
	localparam logic [3:0] OPC_SYS  = 4'h0;
	localparam logic [3:0] OPC_JP   = 4'h1;
	localparam logic [3:0] OPC_CALL = 4'h2;
	localparam logic [3:0] OPC_SE   = 4'h3;
	localparam logic [3:0] OPC_SNE  = 4'h4;
	localparam logic [3:0] OPC_SER  = 4'h5;
	localparam logic [3:0] OPC_LD   = 4'h6;
	localparam logic [3:0] OPC_ADD  = 4'h7;
	localparam logic [3:0] OPC_ALU  = 4'h8;
	localparam logic [3:0] OPC_SNER = 4'h9;
	localparam logic [3:0] OPC_LDI  = 4'hA;
	localparam logic [3:0] OPC_JPV  = 4'hB;
	localparam logic [3:0] OPC_RND  = 4'hC;
	localparam logic [3:0] OPC_DRW  = 4'hD;
	localparam logic [3:0] OPC_KEY  = 4'hE;
	localparam logic [3:0] OPC_MISC = 4'hF;

	// alu sub-codes
	localparam logic [3:0] ALU_MOV  = 4'h0;
	localparam logic [3:0] ALU_OR   = 4'h1;
	localparam logic [3:0] ALU_AND  = 4'h2;
	localparam logic [3:0] ALU_XOR  = 4'h3;
	localparam logic [3:0] ALU_ADD  = 4'h4;
	localparam logic [3:0] ALU_SUB  = 4'h5;
	localparam logic [3:0] ALU_SHR  = 4'h6;
	localparam logic [3:0] ALU_SUBN = 4'h7;
	localparam logic [3:0] ALU_SHL  = 4'hE;

	// low-order sub-codes
	localparam logic [11:0] SYS_CLS  = 12'h0E0;
	localparam logic [11:0] SYS_RET  = 12'h0EE;
	localparam logic [7:0]  KK_SKP   = 8'h9E;
	localparam logic [7:0]  KK_SKNP  = 8'hA1;
	localparam logic [7:0]  KK_GDLY  = 8'h07;
	localparam logic [7:0]  KK_WKEY  = 8'h0A;
	localparam logic [7:0]  KK_SDLY  = 8'h15;
	localparam logic [7:0]  KK_SSND  = 8'h18;
	localparam logic [7:0]  KK_ADDI  = 8'h1E;
	localparam logic [7:0]  KK_FONT  = 8'h29;
	localparam logic [7:0]  KK_BCD   = 8'h33;
	localparam logic [7:0]  KK_STORE = 8'h55;
	localparam logic [7:0]  KK_LOAD  = 8'h65;

	// datapath micro-ops
	typedef logic [4:0] uop_t;
	localparam uop_t U_NOP    = 5'd0;
	localparam uop_t U_CLR    = 5'd1;
	localparam uop_t U_PROG   = 5'd2;
	localparam uop_t U_ROW    = 5'd3;
	localparam uop_t U_FHI    = 5'd4;
	localparam uop_t U_FLO    = 5'd5;
	localparam uop_t U_DEC    = 5'd6;
	localparam uop_t U_RDX    = 5'd7;
	localparam uop_t U_RDY    = 5'd8;
	localparam uop_t U_FLAG   = 5'd9;
	localparam uop_t U_DRW_RD = 5'd10;
	localparam uop_t U_DRW_WR = 5'd11;
	localparam uop_t U_DFLAG  = 5'd12;
	localparam uop_t U_BCD    = 5'd13;
	localparam uop_t U_STORE  = 5'd14;
	localparam uop_t U_LDRD   = 5'd15;
	localparam uop_t U_LDWR   = 5'd16;
	localparam uop_t U_EXEC   = 5'd17;
	localparam uop_t U_PUB    = 5'd18;

	typedef struct packed {
		uop_t              uop;
		logic [MEM_AW-1:0] cnt;
	} dp_cmd_t;

	typedef struct packed {
		logic [15:0] op;
	} dp_sts_t;

	function automatic logic [7:0] font_init(input logic [MEM_AW-1:0] a);
		logic [MEM_AW-1:0] off;
		off = a - MEM_AW'(FONT_BASE);
		if (a >= MEM_AW'(FONT_BASE) && off < MEM_AW'(GLYPH_BYTES))
			return GLYPHS[off[6:0]];
		return 8'd0;
	endfunction

	function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
		logic [1:0]  h;
		logic [7:0]  hv;
		logic [6:0]  r;
		logic [14:0] t;
		logic [3:0]  tens;
		logic [3:0]  ones;
		h = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
		hv = (v >= 8'd200) ? 8'd200 : ((v >= 8'd100) ? 8'd100 : 8'd0);
		r = 7'(v - hv);
		t = 15'(r) * 15'd205;
		tens = 4'(t >> 11);
		ones = 4'(r - 7'(tens) * 7'd10);
		if (sel == 2'd0)
			return {6'd0, h};
		else if (sel == 2'd1)
			return {4'd0, tens};
		return {4'd0, ones};
	endfunction

endpackage
`default_nettype wire

// ===== sv/c8_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module c8_ctrl import c8_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  logic [1:0] mode,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	localparam logic [4:0] S_CLEAR  = 5'd0;
	localparam logic [4:0] S_IDLE   = 5'd1;
	localparam logic [4:0] S_PROG   = 5'd2;
	localparam logic [4:0] S_ROW    = 5'd3;
	localparam logic [4:0] S_FHI    = 5'd4;
	localparam logic [4:0] S_FLO    = 5'd5;
	localparam logic [4:0] S_DEC    = 5'd6;
	localparam logic [4:0] S_RDX    = 5'd7;
	localparam logic [4:0] S_RDY    = 5'd8;
	localparam logic [4:0] S_FLAG   = 5'd9;
	localparam logic [4:0] S_DRW_RD = 5'd10;
	localparam logic [4:0] S_DRW_WR = 5'd11;
	localparam logic [4:0] S_DFLAG  = 5'd12;
	localparam logic [4:0] S_BCD    = 5'd13;
	localparam logic [4:0] S_STORE  = 5'd14;
	localparam logic [4:0] S_LDRD   = 5'd15;
	localparam logic [4:0] S_LDWR   = 5'd16;
	localparam logic [4:0] S_EXEC   = 5'd17;
	localparam logic [4:0] S_DONE   = 5'd18;

	logic [4:0]        st_q, st_d;
	logic [MEM_AW-1:0] cnt_q, cnt_d;
	logic              out_valid_q;
	logic [3:0]        opg, x, n;
	logic [7:0]        kk;
	logic              pub;

	assign opg = sts.op[15:12];
	assign x   = sts.op[11:8];
	assign n   = sts.op[3:0];
	assign kk  = sts.op[7:0];
	assign out_valid = out_valid_q;
	assign pub = (cmd.uop == U_PUB);

	always_comb begin
		st_d     = st_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd.uop  = U_NOP;
		cmd.cnt  = cnt_q;
		unique case (st_q)
			S_CLEAR: begin
				cmd.uop = U_CLR;
				cnt_d   = cnt_q + 1'b1;
				if (cnt_q == MEM_AW'(MEM_BYTES - 1)) begin
					cnt_d = '0;
					st_d  = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (mode)
						MODE_PROG: st_d = S_PROG;
						MODE_EXEC: st_d = S_FHI;
						MODE_ROW:  st_d = S_ROW;
						default:   st_d = S_DONE;
					endcase
				end
			end
			S_PROG: begin
				cmd.uop = U_PROG;
				st_d    = S_DONE;
			end
			S_ROW: begin
				cmd.uop = U_ROW;
				st_d    = S_DONE;
			end
			S_FHI: begin
				cmd.uop = U_FHI;
				st_d    = S_FLO;
			end
			S_FLO: begin
				cmd.uop = U_FLO;
				st_d    = S_DEC;
			end
			S_DEC: begin
				cmd.uop = U_DEC;
				st_d    = S_RDX;
			end
			S_RDX: begin
				cmd.uop = U_RDX;
				st_d    = S_RDY;
			end
			S_RDY: begin
				cmd.uop = U_RDY;
				cnt_d   = '0;
				priority if (opg == OPC_ALU && (n == ALU_ADD || n == ALU_SUB
						|| n == ALU_SHR || n == ALU_SUBN || n == ALU_SHL))
					st_d = S_FLAG;
				else if (opg == OPC_DRW)
					st_d = (n == 4'd0) ? S_DFLAG : S_DRW_RD;
				else if (opg == OPC_MISC && kk == KK_BCD)
					st_d = S_BCD;
				else if (opg == OPC_MISC && kk == KK_STORE)
					st_d = S_STORE;
				else if (opg == OPC_MISC && kk == KK_LOAD)
					st_d = S_LDRD;
				else
					st_d = S_EXEC;
			end
			S_FLAG: begin
				cmd.uop = U_FLAG;
				st_d    = S_EXEC;
			end
			S_DRW_RD: begin
				cmd.uop = U_DRW_RD;
				st_d    = S_DRW_WR;
			end
			S_DRW_WR: begin
				cmd.uop = U_DRW_WR;
				if (cnt_q[3:0] == n - 4'd1) begin
					st_d = S_DFLAG;
				end else begin
					cnt_d = cnt_q + 1'b1;
					st_d  = S_DRW_RD;
				end
			end
			S_DFLAG: begin
				cmd.uop = U_DFLAG;
				st_d    = S_EXEC;
			end
			S_BCD: begin
				cmd.uop = U_BCD;
				if (cnt_q[1:0] == 2'd2)
					st_d = S_EXEC;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_STORE: begin
				cmd.uop = U_STORE;
				if (cnt_q[3:0] == x)
					st_d = S_EXEC;
				else
					cnt_d = cnt_q + 1'b1;
			end
			S_LDRD: begin
				cmd.uop = U_LDRD;
				st_d    = S_LDWR;
			end
			S_LDWR: begin
				cmd.uop = U_LDWR;
				if (cnt_q[3:0] == x) begin
					st_d = S_EXEC;
				end else begin
					cnt_d = cnt_q + 1'b1;
					st_d  = S_LDRD;
				end
			end
			S_EXEC: begin
				cmd.uop = U_EXEC;
				st_d    = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.uop = U_PUB;
					st_d    = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			if (pub)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== sv/c8_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module c8_dp import c8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_fire,
	input  logic [11:0] load_address,
	input  logic [7:0]  load_data,
	input  logic [15:0] key_mask,
	input  logic [7:0]  random_byte,
	input  logic [4:0]  read_row,
	input  dp_cmd_t     cmd,
	output dp_sts_t     sts,
	output logic [11:0] program_counter,
	output logic [63:0] row_pixels,
	output logic        sound_active,
	output logic        awaiting_key,
	output logic        display_changed,
	output logic        bad_opcode
);

	logic [7:0]  mem [MEM_BYTES];
	logic [7:0]  mem_q;
	logic [7:0]  vreg_q [16];
	logic [11:0] stack [STACK_DEPTH];
	logic [11:0] stk_q;
	logic [63:0] fb_q [SCREEN_HEIGHT];

	logic [11:0]     pc_q, idx_q;
	logic [7:0]      dly_q, snd_q;
	logic [SP_W-1:0] sp_q, sp_inc, sp_dec;

	logic [11:0] ld_addr_q;
	logic [7:0]  ld_data_q, rnd_q;
	logic [15:0] keys_q;
	logic [4:0]  row_sel_q;
	logic [15:0] op_q;
	logic [7:0]  vx_q, vy_q;
	logic        coll_q, wait_q, chg_q, bad_q;
	logic [63:0] row_q;

	logic [11:0] out_pc_q;
	logic [63:0] out_row_q;
	logic        out_snd_q, out_wait_q, out_chg_q, out_bad_q;

	logic [3:0]  opg, x, y, n, cnt4;
	logic [7:0]  kk;
	logic [11:0] nnn;

	logic [MEM_AW-1:0] mem_addr;
	logic              mem_we;
	logic [7:0]        mem_wd;

	logic [3:0]  reg_ra, reg_wa;
	logic [7:0]  reg_rd, reg_wd;
	logic        reg_we;

	logic        flag_val;
	logic [7:0]  alu_res;
	logic        alu_ok;
	logic [5:0]  line;
	logic        line_ok;
	logic [4:0]  fb_ra;
	logic [63:0] fb_rd, sprite;
	logic [3:0]  key_idx;
	logic        key_hit;

	logic [11:0] ex_pc, p2, p4;
	logic        ex_we, ex_push, ex_pop, ex_clr, ex_chg, ex_bad, ex_wait;
	logic        ex_idx_we, ex_dly_set, ex_snd_set;
	logic [7:0]  ex_wd;
	logic [11:0] ex_idx;
	logic [7:0]  dly_n, snd_n;
	logic        is_exec;

	assign opg  = op_q[15:12];
	assign x    = op_q[11:8];
	assign y    = op_q[7:4];
	assign n    = op_q[3:0];
	assign kk   = op_q[7:0];
	assign nnn  = op_q[11:0];
	assign cnt4 = cmd.cnt[3:0];
	assign sts.op  = op_q;
	assign is_exec = (cmd.uop == U_EXEC);

	assign sp_inc = (sp_q == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_q + 1'b1;
	assign sp_dec = (sp_q == '0) ? SP_W'(STACK_DEPTH - 1) : sp_q - 1'b1;

	// memory port
	always_comb begin
		mem_we = 1'b0;
		mem_wd = 8'd0;
		unique case (cmd.uop)
			U_CLR: begin
				mem_addr = cmd.cnt;
				mem_we   = 1'b1;
				mem_wd   = font_init(cmd.cnt);
			end
			U_PROG: begin
				mem_addr = ld_addr_q;
				mem_we   = 1'b1;
				mem_wd   = ld_data_q;
			end
			U_FLO:    mem_addr = pc_q + 12'd1;
			U_DRW_RD: mem_addr = idx_q + {8'd0, cnt4};
			U_LDRD:   mem_addr = idx_q + {8'd0, cnt4};
			U_BCD: begin
				mem_addr = idx_q + {8'd0, cnt4};
				mem_we   = 1'b1;
				mem_wd   = bcd_digit(vx_q, cmd.cnt[1:0]);
			end
			U_STORE: begin
				mem_addr = idx_q + {8'd0, cnt4};
				mem_we   = 1'b1;
				mem_wd   = reg_rd;
			end
			default: mem_addr = pc_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_addr] <= mem_wd;
		mem_q <= mem[mem_addr];
	end

	// register file read
	always_comb begin
		unique case (cmd.uop)
			U_RDX:   reg_ra = x;
			U_RDY:   reg_ra = (opg == OPC_JPV) ? 4'd0 : y;
			default: reg_ra = cnt4;
		endcase
	end
	assign reg_rd = vreg_q[reg_ra];

	// alu and flag
	always_comb begin
		alu_ok   = 1'b1;
		alu_res  = 8'd0;
		flag_val = 1'b0;
		unique case (n)
			ALU_MOV: alu_res = vy_q;
			ALU_OR:  alu_res = vx_q | vy_q;
			ALU_AND: alu_res = vx_q & vy_q;
			ALU_XOR: alu_res = vx_q ^ vy_q;
			ALU_ADD: begin
				{flag_val, alu_res} = {1'b0, vx_q} + {1'b0, vy_q};
			end
			ALU_SUB: begin
				alu_res  = vx_q - vy_q;
				flag_val = (vx_q >= vy_q);
			end
			ALU_SHR: begin
				alu_res  = {1'b0, vx_q[7:1]};
				flag_val = vx_q[0];
			end
			ALU_SUBN: begin
				alu_res  = vy_q - vx_q;
				flag_val = (vy_q >= vx_q);
			end
			ALU_SHL: begin
				alu_res  = {vx_q[6:0], 1'b0};
				flag_val = vx_q[7];
			end
			default: alu_ok = 1'b0;
		endcase
	end

	// sprite row
	assign line    = {1'b0, vy_q[ROW_W-1:0]} + {2'd0, cnt4};
	assign line_ok = !line[ROW_W];
	assign fb_ra   = (cmd.uop == U_ROW) ? row_sel_q : line[ROW_W-1:0];
	assign fb_rd   = fb_q[fb_ra];
	assign sprite  = {mem_q, 56'd0} >> vx_q[COL_W-1:0];

	// lowest held key
	always_comb begin
		key_idx = 4'd0;
		for (int i = 15; i >= 0; i--)
			if (keys_q[i])
				key_idx = 4'(i);
	end
	assign key_hit = |keys_q;

	// instruction execute
	assign p2 = pc_q + 12'd2;
	assign p4 = pc_q + 12'd4;

	always_comb begin
		ex_pc      = p2;
		ex_we      = 1'b0;
		ex_wd      = 8'd0;
		ex_push    = 1'b0;
		ex_pop     = 1'b0;
		ex_clr     = 1'b0;
		ex_chg     = 1'b0;
		ex_bad     = 1'b0;
		ex_wait    = 1'b0;
		ex_idx_we  = 1'b0;
		ex_idx     = idx_q;
		ex_dly_set = 1'b0;
		ex_snd_set = 1'b0;
		unique case (opg)
			OPC_SYS: begin
				if (nnn == SYS_CLS) begin
					ex_clr = 1'b1;
					ex_chg = 1'b1;
				end else if (nnn == SYS_RET) begin
					ex_pop = 1'b1;
					ex_pc  = stk_q;
				end else begin
					ex_bad = 1'b1;
				end
			end
			OPC_JP: ex_pc = nnn;
			OPC_CALL: begin
				ex_push = 1'b1;
				ex_pc   = nnn;
			end
			OPC_SE:  if (vx_q == kk) ex_pc = p4;
			OPC_SNE: if (vx_q != kk) ex_pc = p4;
			OPC_SER: begin
				if (n != 4'd0) ex_bad = 1'b1;
				else if (vx_q == vy_q) ex_pc = p4;
			end
			OPC_LD: begin
				ex_we = 1'b1;
				ex_wd = kk;
			end
			OPC_ADD: begin
				ex_we = 1'b1;
				ex_wd = vx_q + kk;
			end
			OPC_ALU: begin
				ex_we  = alu_ok;
				ex_wd  = alu_res;
				ex_bad = !alu_ok;
			end
			OPC_SNER: begin
				if (n != 4'd0) ex_bad = 1'b1;
				else if (vx_q != vy_q) ex_pc = p4;
			end
			OPC_LDI: begin
				ex_idx_we = 1'b1;
				ex_idx    = nnn;
			end
			OPC_JPV: ex_pc = {4'd0, vy_q} + nnn;
			OPC_RND: begin
				ex_we = 1'b1;
				ex_wd = rnd_q & kk;
			end
			OPC_DRW: ex_chg = 1'b1;
			OPC_KEY: begin
				if (kk == KK_SKP) begin
					if (keys_q[vx_q[3:0]]) ex_pc = p4;
				end else if (kk == KK_SKNP) begin
					if (!keys_q[vx_q[3:0]]) ex_pc = p4;
				end else begin
					ex_bad = 1'b1;
				end
			end
			default: begin
				unique case (kk)
					KK_GDLY: begin
						ex_we = 1'b1;
						ex_wd = dly_q;
					end
					KK_WKEY: begin
						if (!key_hit) begin
							ex_pc   = pc_q;
							ex_wait = 1'b1;
						end else begin
							ex_we = 1'b1;
							ex_wd = {4'd0, key_idx};
						end
					end
					KK_SDLY: ex_dly_set = 1'b1;
					KK_SSND: ex_snd_set = 1'b1;
					KK_ADDI: begin
						ex_idx_we = 1'b1;
						ex_idx    = idx_q + {4'd0, vx_q};
					end
					KK_FONT: begin
						ex_idx_we = 1'b1;
						ex_idx    = 12'(FONT_BASE) + {6'd0, vx_q[3:0], 2'd0}
							+ {8'd0, vx_q[3:0]};
					end
					KK_BCD, KK_STORE, KK_LOAD: ex_bad = 1'b0;
					default: ex_bad = 1'b1;
				endcase
			end
		endcase
	end

	assign dly_n = ex_dly_set ? vx_q : dly_q;
	assign snd_n = ex_snd_set ? vx_q : snd_q;

	// register file write port
	always_comb begin
		reg_we = 1'b0;
		reg_wa = x;
		reg_wd = 8'd0;
		unique case (cmd.uop)
			U_FLAG: begin
				reg_we = 1'b1;
				reg_wa = 4'hF;
				reg_wd = {7'd0, flag_val};
			end
			U_DFLAG: begin
				reg_we = 1'b1;
				reg_wa = 4'hF;
				reg_wd = {7'd0, coll_q};
			end
			U_LDWR: begin
				reg_we = 1'b1;
				reg_wa = cnt4;
				reg_wd = mem_q;
			end
			U_EXEC: begin
				reg_we = ex_we;
				reg_wd = ex_wd;
			end
			default: reg_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				vreg_q[i] <= 8'd0;
		end else if (reg_we) begin
			vreg_q[reg_wa] <= reg_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SCREEN_HEIGHT; i++)
				fb_q[i] <= 64'd0;
		end else if (is_exec && ex_clr) begin
			for (int i = 0; i < SCREEN_HEIGHT; i++)
				fb_q[i] <= 64'd0;
		end else if (cmd.uop == U_DRW_WR && line_ok) begin
			fb_q[line[ROW_W-1:0]] <= fb_rd ^ sprite;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q  <= MEM_AW'(PROGRAM_BASE);
			idx_q <= '0;
			dly_q <= '0;
			snd_q <= '0;
			sp_q  <= '0;
		end else if (is_exec) begin
			pc_q  <= ex_pc;
			dly_q <= (dly_n != 8'd0) ? dly_n - 8'd1 : 8'd0;
			snd_q <= (snd_n != 8'd0) ? snd_n - 8'd1 : 8'd0;
			if (ex_idx_we)
				idx_q <= ex_idx;
			if (ex_push)
				sp_q <= sp_inc;
			else if (ex_pop)
				sp_q <= sp_dec;
		end
	end

	always_ff @(posedge clk) begin
		if (is_exec && ex_push)
			stack[sp_q] <= p2;
		stk_q <= stack[sp_dec];
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ld_addr_q <= load_address;
			ld_data_q <= load_data;
			keys_q    <= key_mask;
			rnd_q     <= random_byte;
			row_sel_q <= read_row;
			row_q     <= 64'd0;
			wait_q    <= 1'b0;
			chg_q     <= 1'b0;
			bad_q     <= 1'b0;
			coll_q    <= 1'b0;
		end
		if (cmd.uop == U_FLO)
			op_q[15:8] <= mem_q;
		if (cmd.uop == U_DEC)
			op_q[7:0] <= mem_q;
		if (cmd.uop == U_RDX)
			vx_q <= reg_rd;
		if (cmd.uop == U_RDY)
			vy_q <= reg_rd;
		if (cmd.uop == U_ROW)
			row_q <= fb_rd;
		if (cmd.uop == U_DRW_WR && line_ok && |(fb_rd & sprite))
			coll_q <= 1'b1;
		if (is_exec) begin
			wait_q <= ex_wait;
			chg_q  <= ex_chg;
			bad_q  <= ex_bad;
		end
		if (cmd.uop == U_PUB) begin
			out_pc_q   <= pc_q;
			out_row_q  <= row_q;
			out_snd_q  <= (snd_q != 8'd0);
			out_wait_q <= wait_q;
			out_chg_q  <= chg_q;
			out_bad_q  <= bad_q;
		end
	end

	assign program_counter = out_pc_q;
	assign row_pixels      = out_row_q;
	assign sound_active    = out_snd_q;
	assign awaiting_key    = out_wait_q;
	assign display_changed = out_chg_q;
	assign bad_opcode      = out_bad_q;

endmodule
`default_nettype wire

// ===== sv/chip8_instruction_core_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel  | handshake              | beat contents
// ---------+------------------------+-------------------------------------------------
// in       | in_valid / in_ready    | mode, load_address, load_data, key_mask,
//          |                        | random_byte, read_row
// out      | out_valid / out_ready  | program_counter, row_pixels, sound_active,
//          |                        | awaiting_key, display_changed, bad_opcode
//
// sequence: program write and row read pass their own state, then done; an
//   instruction fetches, reads two registers, may write VF and executes, plus a
//   read and a write per sprite row or Fx65 register, a write per Fx33/Fx55 byte
// reset: a pass over all of memory writes the font and zeros, in_ready low
// stalls: a finished beat sits in the output register while the next beat runs;
//   a second result waits in the done state until the output register frees
module chip8_instruction_core_unit import c8_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [11:0] load_address,
	input  logic [7:0]  load_data,
	input  logic [15:0] key_mask,
	input  logic [7:0]  random_byte,
	input  logic [4:0]  read_row,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] program_counter,
	output logic [63:0] row_pixels,
	output logic        sound_active,
	output logic        awaiting_key,
	output logic        display_changed,
	output logic        bad_opcode
);

	// command and status between sequencer and datapath
	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    in_fire;

	// an input beat is taken only in the idle state
	assign in_fire = in_valid & in_ready;

	c8_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// memory, registers, stack, timers and frame buffer
	c8_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_fire         (in_fire),
		.load_address    (load_address),
		.load_data       (load_data),
		.key_mask        (key_mask),
		.random_byte     (random_byte),
		.read_row        (read_row),
		.cmd             (cmd),
		.sts             (sts),
		.program_counter (program_counter),
		.row_pixels      (row_pixels),
		.sound_active    (sound_active),
		.awaiting_key    (awaiting_key),
		.display_changed (display_changed),
		.bad_opcode      (bad_opcode)
	);

endmodule
`default_nettype wire
